/* rtl/core/yps_pkg.sv */
// yps_pkg: shared types, widths and constants of the plane sse / psnr meter
// no dependencies
`timescale 1ns / 1ps
package yps_pkg;

  // defaults of the top level parameters
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int DEF_FRAC_BITS  = 8;

  // register map
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 13;
  localparam logic [CFG_AW-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_DW-1:0] RST_FRAME_WIDTH  = 13'd176;
  localparam logic [CFG_DW-1:0] RST_FRAME_HEIGHT = 13'd144;

  // plane codes
  localparam logic [1:0] PLANE_Y = 2'd0;
  localparam logic [1:0] PLANE_U = 2'd1;
  localparam logic [1:0] PLANE_V = 2'd2;

  // datapath widths
  localparam int DIM_W   = 14;  // clamped dimension, up to 8192
  localparam int TGT_W   = 27;  // plane size, up to 8192*8192
  localparam int CNT_W   = 24;  // sample counter, wraps
  localparam int ACC_W   = 41;  // sse accumulator
  localparam int FRM_W   = 16;
  localparam int SSE_W   = 40;
  localparam int AVS_W   = 48;
  localparam int PSNR_W  = 15;
  localparam int LOG_IW  = 43;  // log input, covers 65025 * plane size
  localparam int LOG_PW  = 6;   // integer part of log2
  localparam int LOG_FW  = 16;  // fraction bits of log2
  localparam int LOG_W   = LOG_PW + LOG_FW;
  localparam int MANT_W  = 31;  // Q30 mantissa
  localparam int NUM_W   = 64;  // dividend of the running mean
  localparam int DEN_W   = 17;

  localparam logic [15:0] PEAK_SQ        = 16'd65025;
  localparam logic [25:0] TEN_LOG10_2_Q24 = 26'd50504453;
  localparam logic [FRM_W-1:0] FRAME_SAT = 16'hFFFF;

  // plane queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = 1;

  // one finished plane waiting for the back end
  typedef struct packed {
    logic [1:0]       plane;
    logic [FRM_W-1:0] frame;
    logic [ACC_W-1:0] sse;
    logic [TGT_W-1:0] target;
  } yps_rec_t;

endpackage

/* rtl/core/yuv_plane_sse_psnr_meter_unit.sv */
// yuv_plane_sse_psnr_meter_unit: top level of the plane sse / psnr meter
// depends on yps_pkg, yps_front, yps_fifo, yps_back
//
// Usage:
//   input channel: push ref/test sample pairs while full is low, in file order
//   of 4:2:0 frames (Y plane, then U, then V). One pair is taken per cycle.
//   result channel: one result per finished plane, held while empty is low
//   and removed by pop. Fields: plane, frame index, sse, psnr and the running
//   means of sse and psnr for that plane; psnr and both means in 1/256 units.
//   configuration: cfg_we writes frame_width (index 0) or frame_height
//   (index 1); write only while no plane is in flight.
// Processing:
//   after a plane's last sample the back end produces its result with
//   two iterative log2 passes (shift normalize, then 16 squarings each)
//   and two restoring divisions for the means.
//   The back end handles one plane at a time; a two-entry plane queue lets
//   the front keep taking a sample every cycle meanwhile. full rises only
//   when planes end faster than the back end retires them (tiny planes).
//   A stalled receiver holds the result; the back end then waits and the
//   queue fills behind it.
// Reset: clears counters, means, queue and result; sizes return to 176x144.
`timescale 1ns / 1ps
module yuv_plane_sse_psnr_meter_unit #(
  parameter int MAX_WIDTH  = yps_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = yps_pkg::DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = yps_pkg::DEF_FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [yps_pkg::CFG_AW-1:0] cfg_index,
  input  logic [yps_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [7:0]                 in_ref_sample,
  input  logic [7:0]                 in_test_sample,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [1:0]                 out_plane,
  output logic [yps_pkg::FRM_W-1:0]  out_frame_index,
  output logic [yps_pkg::SSE_W-1:0]  out_sse,
  output logic [yps_pkg::PSNR_W-1:0] out_psnr_q8,
  output logic [yps_pkg::AVS_W-1:0]  out_avg_sse_q8,
  output logic [yps_pkg::PSNR_W-1:0] out_avg_psnr_q8
);
  import yps_pkg::*;

  yps_rec_t push_rec, pop_rec;
  logic     q_push, q_full, q_pop, q_empty;

  yps_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_ref_sample  (in_ref_sample),
    .in_test_sample (in_test_sample),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (push_rec)
  );

  yps_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (push_rec),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (pop_rec),
    .empty (q_empty)
  );

  yps_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_data          (pop_rec),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_plane       (out_plane),
    .out_frame_index (out_frame_index),
    .out_sse         (out_sse),
    .out_psnr_q8     (out_psnr_q8),
    .out_avg_sse_q8  (out_avg_sse_q8),
    .out_avg_psnr_q8 (out_avg_psnr_q8)
  );

endmodule

/* rtl/core/yps_front.sv */
// yps_front: configuration registers, per-sample sse accumulation and plane end detection
// depends on yps_pkg
`timescale 1ns / 1ps
module yps_front #(
  parameter int MAX_WIDTH  = yps_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = yps_pkg::DEF_MAX_HEIGHT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [yps_pkg::CFG_AW-1:0] cfg_index,
  input  logic [yps_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [7:0]                 in_ref_sample,
  input  logic [7:0]                 in_test_sample,
  input  logic                       q_full,
  output logic                       q_push,
  output yps_pkg::yps_rec_t          q_data
);
  import yps_pkg::*;

  localparam logic [DIM_W-1:0] MAXW = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAXH = DIM_W'(MAX_HEIGHT);

  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_DW-1:0] v,
                                               input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] e;
    e = {1'b0, v[CFG_DW-1:1], 1'b0};
    if (e < DIM_W'(2)) e = DIM_W'(2);
    if (e > maxv) e = maxv;
    return e;
  endfunction

  logic [CFG_DW-1:0] width_r, height_r;
  logic [TGT_W-1:0]  tgt_luma, tgt_chroma;
  logic [1:0]        plane_r, plane_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [FRM_W-1:0]  frame_r, frame_nxt;
  logic [DIM_W-1:0]  w_eff, h_eff;
  logic [7:0]        diff;
  logic [15:0]       dsq;
  logic [TGT_W-1:0]  target;
  logic              accept, plane_end;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_FRAME_WIDTH;
      height_r <= RST_FRAME_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  width_r  <= cfg_wdata;
        REG_FRAME_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // plane sizes from the size registers
  assign w_eff      = eff_dim(width_r, MAXW);
  assign h_eff      = eff_dim(height_r, MAXH);
  assign tgt_luma   = TGT_W'(w_eff) * TGT_W'(h_eff);
  assign tgt_chroma = TGT_W'(w_eff >> 1) * TGT_W'(h_eff >> 1);

  // sample accumulation
  assign in_full   = q_full;
  assign accept    = in_push && !q_full;
  assign target    = (plane_r == PLANE_Y) ? tgt_luma : tgt_chroma;
  assign diff      = (in_ref_sample > in_test_sample) ? in_ref_sample - in_test_sample
                                                       : in_test_sample - in_ref_sample;
  assign dsq       = 16'(diff) * 16'(diff);
  assign acc_nxt   = acc_r + ACC_W'(dsq);
  assign cnt_nxt   = cnt_r + CNT_W'(1);
  assign plane_end = ({{(TGT_W-CNT_W){1'b0}}, cnt_nxt} >= target) || (cnt_nxt == '0);

  assign q_push        = accept && plane_end;
  assign q_data.plane  = plane_r;
  assign q_data.frame  = frame_r;
  assign q_data.sse    = acc_nxt;
  assign q_data.target = target;

  // plane and frame sequencing
  always_comb begin
    plane_nxt = plane_r;
    frame_nxt = frame_r;
    if (plane_r >= PLANE_V) begin
      plane_nxt = PLANE_Y;
      if (frame_r != FRAME_SAT) frame_nxt = frame_r + FRM_W'(1);
    end else begin
      plane_nxt = plane_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r <= PLANE_Y;
      cnt_r   <= '0;
      acc_r   <= '0;
      frame_r <= '0;
    end else if (accept) begin
      if (plane_end) begin
        cnt_r   <= '0;
        acc_r   <= '0;
        plane_r <= plane_nxt;
        frame_r <= frame_nxt;
      end else begin
        cnt_r <= cnt_nxt;
        acc_r <= acc_nxt;
      end
    end
  end

endmodule

/* rtl/core/yps_fifo.sv */
// yps_fifo: short queue of finished plane requests between front and back
// depends on yps_pkg
`timescale 1ns / 1ps
module yps_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  yps_pkg::yps_rec_t wdata,
  output logic              full,
  input  logic              pop,
  output yps_pkg::yps_rec_t rdata,
  output logic              empty
);
  import yps_pkg::*;

  yps_rec_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]     wr_r, rd_r;
  logic [FIFO_AW:0]       cnt_r;
  logic                   do_push, do_pop;

  assign full    = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= wdata;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + FIFO_AW'(1);
      if (do_pop)  rd_r <= rd_r + FIFO_AW'(1);
      if (do_push && !do_pop) cnt_r <= cnt_r + (FIFO_AW+1)'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - (FIFO_AW+1)'(1);
    end
  end

endmodule

/* rtl/core/yps_log2.sv */
// yps_log2: iterative log2 in Q16, shift normalize then 16 squarings
// depends on yps_pkg
`timescale 1ns / 1ps
module yps_log2 (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [yps_pkg::LOG_IW-1:0] x,
  output logic                       done,
  output logic [yps_pkg::LOG_W-1:0]  result
);
  import yps_pkg::*;

  typedef enum logic [2:0] {
    L_IDLE = 3'b001,
    L_NORM = 3'b010,
    L_SQ   = 3'b100
  } lstate_t;

  lstate_t             st_r;
  logic [LOG_IW-1:0]   m_r;
  logic [LOG_PW-1:0]   p_r;
  logic [MANT_W-1:0]   q_r;
  logic [LOG_FW-1:0]   frac_r;
  logic [4:0]          k_r;
  logic                done_r;
  logic [2*MANT_W-1:0] prod;
  logic [MANT_W:0]     sq;

  assign prod   = q_r * q_r;
  assign sq     = prod[2*MANT_W-1:MANT_W-1];
  assign done   = done_r;
  assign result = {p_r, frac_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= L_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        L_IDLE: if (start) st_r <= L_NORM;
        L_NORM: if (m_r[LOG_IW-1]) st_r <= L_SQ;
        L_SQ: if (k_r == 5'd15) begin
          st_r   <= L_IDLE;
          done_r <= 1'b1;
        end
        default: st_r <= L_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (st_r)
      L_IDLE: begin
        m_r <= x;
        p_r <= LOG_PW'(LOG_IW - 1);
      end
      L_NORM: begin
        if (m_r[LOG_IW-1]) begin
          q_r    <= m_r[LOG_IW-1 -: MANT_W];
          k_r    <= '0;
          frac_r <= '0;
        end else begin
          m_r <= m_r << 1;
          p_r <= p_r - LOG_PW'(1);
        end
      end
      L_SQ: begin
        k_r <= k_r + 5'd1;
        // squared mantissa reaching two emits a one and is halved
        if (sq[MANT_W]) begin
          q_r    <= sq[MANT_W:1];
          frac_r <= {frac_r[LOG_FW-2:0], 1'b1};
        end else begin
          q_r    <= sq[MANT_W-1:0];
          frac_r <= {frac_r[LOG_FW-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/core/yps_div.sv */
// yps_div: restoring divider, one quotient bit per cycle
// depends on yps_pkg
`timescale 1ns / 1ps
module yps_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [yps_pkg::NUM_W-1:0] num,
  input  logic [yps_pkg::DEN_W-1:0] den,
  output logic                      done,
  output logic [yps_pkg::NUM_W-1:0] quot
);
  import yps_pkg::*;

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_r, done_r;
  logic [CW-1:0]    k_r;
  logic [NUM_W-1:0] n_r;
  logic [DEN_W-1:0] d_r, rem_r;
  logic [DEN_W:0]   trial;

  assign trial = {rem_r, n_r[NUM_W-1]};
  assign done  = done_r;
  assign quot  = n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        busy_r <= start;
      end else if (k_r == CW'(NUM_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // shift-subtract step, quotient bits enter at the bottom of n_r
  always_ff @(posedge clk) begin
    if (!busy_r) begin
      n_r   <= num;
      d_r   <= den;
      rem_r <= '0;
      k_r   <= '0;
    end else begin
      k_r <= k_r + CW'(1);
      if (trial >= {1'b0, d_r}) begin
        rem_r <= DEN_W'(trial - {1'b0, d_r});
        n_r   <= {n_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[DEN_W-1:0];
        n_r   <= {n_r[NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

/* rtl/core/yps_back.sv */
// yps_back: per-plane psnr, running means and the result register
// depends on yps_pkg, yps_log2, yps_div
`timescale 1ns / 1ps
module yps_back #(
  parameter int FRAC_BITS = yps_pkg::DEF_FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  yps_pkg::yps_rec_t          q_data,
  output logic                       q_pop,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [1:0]                 out_plane,
  output logic [yps_pkg::FRM_W-1:0]  out_frame_index,
  output logic [yps_pkg::SSE_W-1:0]  out_sse,
  output logic [yps_pkg::PSNR_W-1:0] out_psnr_q8,
  output logic [yps_pkg::AVS_W-1:0]  out_avg_sse_q8,
  output logic [yps_pkg::PSNR_W-1:0] out_avg_psnr_q8
);
  import yps_pkg::*;

  localparam int PS_W = 56;

  typedef enum logic [10:0] {
    B_IDLE  = 11'b00000000001,
    B_LOGN  = 11'b00000000010,
    B_WAITN = 11'b00000000100,
    B_LOGD  = 11'b00000001000,
    B_WAITD = 11'b00000010000,
    B_PSNR  = 11'b00000100000,
    B_DIVS  = 11'b00001000000,
    B_WAITS = 11'b00010000000,
    B_DIVP  = 11'b00100000000,
    B_WAITP = 11'b01000000000,
    B_OUT   = 11'b10000000000
  } bstate_t;

  bstate_t            st_r;
  yps_rec_t           rec_r;
  logic [LOG_W-1:0]   ln_r, ld_r;
  logic [PSNR_W-1:0]  psnr_r, avp_new_r;
  logic [AVS_W-1:0]   avs_new_r;
  logic [AVS_W-1:0]   avg_sse_r  [3];
  logic [PSNR_W-1:0]  avg_psnr_r [3];
  logic               out_valid_r;

  logic               log_start, log_done;
  logic [LOG_IW-1:0]  log_x;
  logic [LOG_W-1:0]   log_res;
  logic               div_start, div_done;
  logic [NUM_W-1:0]   div_num, div_q;
  logic [DEN_W-1:0]   den;
  logic [LOG_W-1:0]   ldiff;
  logic [PS_W-1:0]    psum;
  logic               out_free;

  assign den      = DEN_W'(rec_r.frame) + DEN_W'(1);
  assign out_free = !out_valid_r || out_pop;
  assign q_pop    = (st_r == B_IDLE) && !q_empty;

  // log operand: numerator peak energy, then the error clamped to at least one
  always_comb begin
    log_start = (st_r == B_LOGN) || (st_r == B_LOGD);
    if (st_r == B_LOGN) log_x = LOG_IW'(PEAK_SQ) * LOG_IW'(rec_r.target);
    else if (rec_r.sse == '0) log_x = LOG_IW'(1);
    else log_x = LOG_IW'(rec_r.sse);
  end

  // running mean dividend, rounded to nearest
  always_comb begin
    div_start = (st_r == B_DIVS) || (st_r == B_DIVP);
    if (st_r == B_DIVS)
      div_num = NUM_W'(avg_sse_r[rec_r.plane]) * NUM_W'(rec_r.frame)
              + (NUM_W'(rec_r.sse) << FRAC_BITS) + NUM_W'(den >> 1);
    else
      div_num = NUM_W'(avg_psnr_r[rec_r.plane]) * NUM_W'(rec_r.frame)
              + NUM_W'(psnr_r) + NUM_W'(den >> 1);
  end

  // db conversion of the log difference
  assign ldiff = (ln_r > ld_r) ? ln_r - ld_r : '0;
  assign psum  = PS_W'(ldiff) * PS_W'(TEN_LOG10_2_Q24) + (PS_W'(1) << (39 - FRAC_BITS));

  yps_log2 u_log2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (log_start),
    .x      (log_x),
    .done   (log_done),
    .result (log_res)
  );

  yps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (den),
    .done  (div_done),
    .quot  (div_q)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
    end else begin
      case (st_r)
        B_IDLE:  if (!q_empty) st_r <= B_LOGN;
        B_LOGN:  st_r <= B_WAITN;
        B_WAITN: if (log_done) st_r <= B_LOGD;
        B_LOGD:  st_r <= B_WAITD;
        B_WAITD: if (log_done) st_r <= B_PSNR;
        B_PSNR:  st_r <= B_DIVS;
        B_DIVS:  st_r <= B_WAITS;
        B_WAITS: if (div_done) st_r <= B_DIVP;
        B_DIVP:  st_r <= B_WAITP;
        B_WAITP: if (div_done) st_r <= B_OUT;
        B_OUT:   if (out_free) st_r <= B_IDLE;
        default: st_r <= B_IDLE;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (q_pop) rec_r <= q_data;
    if (st_r == B_WAITN && log_done) ln_r <= log_res;
    if (st_r == B_WAITD && log_done) ld_r <= log_res;
    if (st_r == B_PSNR) psnr_r <= psum[40-FRAC_BITS +: PSNR_W];
    if (st_r == B_WAITS && div_done) avs_new_r <= div_q[AVS_W-1:0];
    if (st_r == B_WAITP && div_done) avp_new_r <= div_q[PSNR_W-1:0];
  end

  // per-plane means
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        avg_sse_r[i]  <= '0;
        avg_psnr_r[i] <= '0;
      end
    end else if (st_r == B_OUT && out_free) begin
      avg_sse_r[rec_r.plane]  <= avs_new_r;
      avg_psnr_r[rec_r.plane] <= avp_new_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (st_r == B_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == B_OUT && out_free) begin
      out_plane       <= rec_r.plane;
      out_frame_index <= rec_r.frame;
      out_sse         <= rec_r.sse[SSE_W-1:0];
      out_psnr_q8     <= psnr_r;
      out_avg_sse_q8  <= avs_new_r;
      out_avg_psnr_q8 <= avp_new_r;
    end
  end

  assign out_empty = !out_valid_r;

endmodule

/* rtl/core/yps_checker.sv */
// yps_checker: port level checks of the meter, bound to the top level
// depends on yps_pkg, yuv_plane_sse_psnr_meter_unit
`timescale 1ns / 1ps
module yps_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_full,
  input logic                       out_empty,
  input logic                       out_pop,
  input logic [1:0]                 out_plane,
  input logic [yps_pkg::SSE_W-1:0]  out_sse
);
  import yps_pkg::*;

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result pending after reset");

  // after reset the plane queue is not full, so input is not blocked
  a_rst_full: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input blocked after reset");

  // a waiting result never carries an unused plane code
  a_plane: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_plane == PLANE_Y || out_plane == PLANE_U || out_plane == PLANE_V))
    else $error("bad plane code");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_sse) && $stable(out_plane))
    else $error("result changed while stalled");

endmodule

bind yuv_plane_sse_psnr_meter_unit yps_checker u_yps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_plane (out_plane),
  .out_sse   (out_sse)
);
